// File: sv/fea_pkg.sv
// ----------------------------------------------------------------------------
// fea_pkg: shared types and constants of the free extent allocator
// Holds the table geometry, the request and result words, the table entry,
// the controller states, the datapath commands and the datapath status.
// ----------------------------------------------------------------------------
package fea_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic        op;
        logic [31:0] extent_offset;
        logic [31:0] extent_size;
    } in_word_t;

    typedef struct packed {
        logic [31:0] placed_offset;
        logic        placed_at_end;
        logic        table_full;
    } out_word_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] length;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DROP,
        ST_APPEND,
        ST_INSERT,
        ST_SORT_KEY,
        ST_SORT_LOAD,
        ST_SORT_SHIFT,
        ST_SORT_PLACE,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CAPTURE,
        CMD_SCAN_FIRST,
        CMD_SCAN_NEXT,
        CMD_HIT,
        CMD_DROP,
        CMD_APPEND,
        CMD_INSERT,
        CMD_FULL,
        CMD_KEY_RD,
        CMD_KEY_LOAD,
        CMD_SHIFT,
        CMD_PLACE,
        CMD_RESULT
    } cmd_t;

    typedef struct packed {
        logic req_alloc;   // captured request is an allocate
        logic size_zero;   // captured size is zero
        logic count_zero;  // table is empty
        logic count_full;  // table holds TABLE_DEPTH entries
        logic hit;         // entry on the read port satisfies the request
        logic drop;        // allocate hit leaves a zero-length entry
        logic has_next;    // an entry follows the current scan index
        logic key_ok;      // sort index still inside the table
        logic gt;          // entry on the read port is longer than the sort key
        logic pos_one;     // sort hole sits at index one
        logic out_free;    // result register can take a new word
    } dp_status_t;

endpackage

// File: sv/fea_ram.sv
// ----------------------------------------------------------------------------
// fea_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fea_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/fea_ctrl.sv
// ----------------------------------------------------------------------------
// fea_ctrl: sequencer of the free extent allocator
// Walks each request through scan, drop, append, insert and sort steps and
// issues one datapath command per cycle.
// ----------------------------------------------------------------------------
module fea_ctrl import fea_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (status.req_alloc) begin
                    if (status.count_zero) begin
                        state_next = ST_APPEND;
                    end else begin
                        cmd        = CMD_SCAN_FIRST;
                        state_next = ST_SCAN;
                    end
                end else if (status.size_zero) begin
                    state_next = ST_FINISH;
                end else if (status.count_zero) begin
                    state_next = ST_INSERT;
                end else begin
                    cmd        = CMD_SCAN_FIRST;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.hit) begin
                    cmd = CMD_HIT;
                    if (!status.req_alloc) begin
                        state_next = ST_SORT_KEY;
                    end else if (status.drop && status.has_next) begin
                        state_next = ST_DROP;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else if (status.has_next) begin
                    cmd = CMD_SCAN_NEXT;
                end else if (status.req_alloc) begin
                    state_next = ST_APPEND;
                end else if (status.count_full) begin
                    cmd        = CMD_FULL;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_INSERT;
                end
            end
            ST_DROP: begin
                cmd = CMD_DROP;
                if (!status.has_next) begin
                    state_next = ST_FINISH;
                end
            end
            ST_APPEND: begin
                cmd        = CMD_APPEND;
                state_next = ST_FINISH;
            end
            ST_INSERT: begin
                cmd        = CMD_INSERT;
                state_next = ST_SORT_KEY;
            end
            ST_SORT_KEY: begin
                if (status.key_ok) begin
                    cmd        = CMD_KEY_RD;
                    state_next = ST_SORT_LOAD;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_SORT_LOAD: begin
                cmd        = CMD_KEY_LOAD;
                state_next = ST_SORT_SHIFT;
            end
            ST_SORT_SHIFT: begin
                if (status.gt) begin
                    cmd = CMD_SHIFT;
                    if (status.pos_one) begin
                        state_next = ST_SORT_PLACE;
                    end
                end else begin
                    cmd        = CMD_PLACE;
                    state_next = ST_SORT_KEY;
                end
            end
            ST_SORT_PLACE: begin
                cmd        = CMD_PLACE;
                state_next = ST_SORT_KEY;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd        = CMD_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/fea_dpath.sv
// ----------------------------------------------------------------------------
// fea_dpath: datapath of the free extent allocator
// Holds the extent table RAM, fill count, append pointer, scan and sort
// indexes, the captured request and the result register.
// ----------------------------------------------------------------------------
module fea_dpath import fea_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       cmd,
    input  in_word_t   s_word,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_word
);

    in_word_t    req_reg,        req_next;
    logic [31:0] end_reg,        end_next;
    cnt_t        count_reg,      count_next;
    logic [31:0] append_reg,     append_next;
    cnt_t        idx_reg,        idx_next;
    idx_t        pos_reg,        pos_next;
    entry_t      key_reg,        key_next;
    logic [31:0] res_offset_reg, res_offset_next;
    logic        res_at_end_reg, res_at_end_next;
    logic        res_full_reg,   res_full_next;
    logic        m_valid_reg,    m_valid_next;
    out_word_t   m_word_reg,     m_word_next;

    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    logic   rd_en;
    idx_t   rd_addr;
    logic [$bits(entry_t)-1:0] rd_raw;
    entry_t rd_entry;

    cnt_t idx_inc;
    cnt_t idx_inc2;
    cnt_t idx_dec;
    logic hit_alloc;
    logic hit_release;
    logic start_touch;

    fea_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry = entry_t'(rd_raw);
    assign idx_inc  = idx_reg + cnt_t'(1);
    assign idx_inc2 = idx_reg + cnt_t'(2);
    assign idx_dec  = idx_reg - cnt_t'(1);

    assign hit_alloc   = rd_entry.length >= req_reg.extent_size;
    assign start_touch = end_reg == rd_entry.start;
    assign hit_release = ((rd_entry.start + rd_entry.length) == req_reg.extent_offset)
                         || start_touch;

    always_comb begin
        status.req_alloc  = req_reg.op == OP_ALLOC;
        status.size_zero  = req_reg.extent_size == 32'd0;
        status.count_zero = count_reg == cnt_t'(0);
        status.count_full = count_reg == cnt_t'(TABLE_DEPTH);
        status.hit        = (req_reg.op == OP_ALLOC) ? hit_alloc : hit_release;
        status.drop       = (req_reg.op == OP_ALLOC)
                            && (rd_entry.length == req_reg.extent_size);
        status.has_next   = idx_inc < count_reg;
        status.key_ok     = idx_reg < count_reg;
        status.gt         = rd_entry.length > key_reg.length;
        status.pos_one    = pos_reg == idx_t'(1);
        status.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        req_next        = req_reg;
        end_next        = end_reg;
        count_next      = count_reg;
        append_next     = append_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_offset_next = res_offset_reg;
        res_at_end_next = res_at_end_reg;
        res_full_next   = res_full_reg;
        m_word_next     = m_word_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[IDX_W-1:0];
        wr_data         = rd_entry;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[IDX_W-1:0];

        case (cmd)
            CMD_CAPTURE: begin
                req_next        = s_word;
                end_next        = s_word.extent_offset + s_word.extent_size;
                idx_next        = cnt_t'(0);
                res_offset_next = 32'd0;
                res_at_end_next = 1'b0;
                res_full_next   = 1'b0;
            end
            CMD_SCAN_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = idx_t'(0);
            end
            CMD_SCAN_NEXT: begin
                rd_en    = 1'b1;
                rd_addr  = idx_inc[IDX_W-1:0];
                idx_next = idx_inc;
            end
            CMD_HIT: begin
                if (req_reg.op == OP_ALLOC) begin
                    res_offset_next = rd_entry.start;
                    if (status.drop) begin
                        // drop the emptied entry; pull the next one toward it
                        count_next = count_reg - cnt_t'(1);
                        rd_en      = 1'b1;
                        rd_addr    = idx_inc[IDX_W-1:0];
                    end else begin
                        wr_en          = 1'b1;
                        wr_data.start  = rd_entry.start + req_reg.extent_size;
                        wr_data.length = rd_entry.length - req_reg.extent_size;
                    end
                end else begin
                    wr_en          = 1'b1;
                    wr_data.start  = start_touch ? req_reg.extent_offset : rd_entry.start;
                    wr_data.length = rd_entry.length + req_reg.extent_size;
                    idx_next       = cnt_t'(1);
                end
            end
            CMD_DROP: begin
                wr_en    = 1'b1;
                rd_en    = 1'b1;
                rd_addr  = idx_inc2[IDX_W-1:0];
                idx_next = idx_inc;
            end
            CMD_APPEND: begin
                res_offset_next = append_reg;
                res_at_end_next = 1'b1;
                append_next     = append_reg + req_reg.extent_size;
            end
            CMD_INSERT: begin
                wr_en          = 1'b1;
                wr_addr        = count_reg[IDX_W-1:0];
                wr_data.start  = req_reg.extent_offset;
                wr_data.length = req_reg.extent_size;
                count_next     = count_reg + cnt_t'(1);
                idx_next       = cnt_t'(1);
            end
            CMD_FULL: begin
                res_full_next = 1'b1;
            end
            CMD_KEY_RD: begin
                rd_en = 1'b1;
            end
            CMD_KEY_LOAD: begin
                key_next = rd_entry;
                pos_next = idx_reg[IDX_W-1:0];
                rd_en    = 1'b1;
                rd_addr  = idx_dec[IDX_W-1:0];
            end
            CMD_SHIFT: begin
                // move the longer entry up into the hole
                wr_en    = 1'b1;
                wr_addr  = pos_reg;
                pos_next = pos_reg - idx_t'(1);
                rd_en    = 1'b1;
                rd_addr  = pos_reg - idx_t'(2);
            end
            CMD_PLACE: begin
                wr_en    = 1'b1;
                wr_addr  = pos_reg;
                wr_data  = key_reg;
                idx_next = idx_inc;
            end
            CMD_RESULT: begin
                m_valid_next              = 1'b1;
                m_word_next.placed_offset = res_offset_reg;
                m_word_next.placed_at_end = res_at_end_reg;
                m_word_next.table_full    = res_full_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= cnt_t'(0);
            append_reg  <= 32'd0;
            idx_reg     <= cnt_t'(0);
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            append_reg  <= append_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        end_reg        <= end_next;
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_offset_reg <= res_offset_next;
        res_at_end_reg <= res_at_end_next;
        res_full_reg   <= res_full_next;
        m_word_reg     <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // every table write lands inside the live part of the table
    a_write_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (cnt_t'(wr_addr) < count_next))
        else $error("table write beyond fill count");

    // the fill count moves by at most one per cycle
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (count_reg == $past(count_reg)
                            || count_reg == $past(count_reg) + cnt_t'(1)
                            || count_reg + cnt_t'(1) == $past(count_reg)))
        else $error("fill count jumped");

    // the append pointer moves only on an append step or reset
    a_append_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (append_reg != $past(append_reg))
            |-> ($past(cmd == CMD_APPEND) || !$past(aresetn)))
        else $error("append pointer moved outside an append");

    // a full flag goes out only while the table is full
    a_full_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd == CMD_RESULT && res_full_reg) |-> (count_reg == cnt_t'(TABLE_DEPTH)))
        else $error("table full flagged with room left");

endmodule

// File: sv/free_extent_allocator.sv
// ----------------------------------------------------------------------------
// free_extent_allocator: first-fit free extent table with append pointer
// Allocates and releases extents of a storage space, one request at a time.
// ----------------------------------------------------------------------------
// Each request word is handled to completion before the next is taken, and
// every request yields exactly one result word. Timing is set by the single
// read port of the extent table RAM, one entry per cycle. An allocate scans
// the entries up to the fitting one, then pulls the following entries down
// when the fitting extent is used up, or appends at the pointer when nothing
// fits. A release of nonzero size scans the same way, inserts a new entry
// when nothing merges, then runs a stable insertion sort over the n live
// entries; with the table full and nothing to merge it flags the table full
// and skips the sort. An allocate does not re-sort the entry it shrinks, so
// the table need not stay sorted between requests and the sort may move any
// entry. A release of size zero returns all-zero fields. The result register
// lets a new request start while the previous result waits; the table itself
// needs no clearing after reset, since only the first fill-count entries are
// read.
// ----------------------------------------------------------------------------
module free_extent_allocator import fea_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_word
);

    // command and status link between sequencer and datapath
    cmd_t       cmd;
    dp_status_t status;

    // sequencer: decide each step from the datapath status
    fea_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: hold the table, counters and result register
    fea_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_word  (s_word),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

// File: tb/tb_free_extent_allocator.sv
// ----------------------------------------------------------------------------
// tb_free_extent_allocator: self-checking bench for the free extent allocator
// Drives allocate and release words through the request channel and compares
// every result word, field by field, with a first-fit table predictor kept in
// step with each accepted request. A short directed table covers the edge
// cases, then constrained-by-hand random traffic runs under several idling
// patterns, including a long result hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module tb_free_extent_allocator;
    import fea_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int TIMEOUT_CYCLES  = 2_000_000;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int PHASE_N         = 4;
    localparam int HOLD_CYCLES     = 400;
    // room for the worst release, which re-sorts a full table
    localparam int SETTLE_CYCLES   = 200;
    localparam int LIVE_MAX        = 64;
    localparam logic [31:0] LIVE_SIZE_MAX = 32'h0000_1000;

    // idling per phase, in percent: free run, sender idle, receiver stall, both
    localparam int SEND_IDLE  [PHASE_N] = '{0, 85, 0, 34};
    localparam int RECV_STALL [PHASE_N] = '{0, 0, 85, 34};

    // one row of the directed table; when known is set, want is the result
    // to expect, otherwise the predictor supplies it
    typedef struct packed {
        logic      known;
        in_word_t  req;
        out_word_t want;
    } probe_t;

    localparam int PROBE_N    = 15;
    // fill the table up to its depth right after this row
    localparam int FILL_AFTER = 11;

    localparam probe_t PROBES [PROBE_N] = '{
        // empty table: allocate of size zero sits at the append pointer
        '{1'b1, '{OP_ALLOC,   32'h0000_0000, 32'h0000_0000}, '{32'h0, 1'b1, 1'b0}},
        '{1'b1, '{OP_ALLOC,   32'hFFFF_FFFF, 32'h0000_0100}, '{32'h0, 1'b1, 1'b0}},
        // release of size zero: all fields zero
        '{1'b1, '{OP_RELEASE, 32'hFFFF_FFFF, 32'h0000_0000}, '{32'h0, 1'b0, 1'b0}},
        '{1'b1, '{OP_RELEASE, 32'h0000_0000, 32'h0000_0040}, '{32'h0, 1'b0, 1'b0}},
        '{1'b1, '{OP_RELEASE, 32'h0000_0080, 32'h0000_0020}, '{32'h0, 1'b0, 1'b0}},
        // merge in front of an entry's start
        '{1'b1, '{OP_RELEASE, 32'h0000_0040, 32'h0000_0040}, '{32'h0, 1'b0, 1'b0}},
        // exact fit uses the extent up and drops it
        '{1'b0, '{OP_ALLOC,   32'h0000_0000, 32'h0000_0040}, '{32'h0, 1'b0, 1'b0}},
        // nothing fits: append pointer wraps
        '{1'b0, '{OP_ALLOC,   32'h0000_0000, 32'hFFFF_FFFF}, '{32'h0, 1'b0, 1'b0}},
        // size zero against a live table takes the first entry untouched
        '{1'b0, '{OP_ALLOC,   32'h0000_0000, 32'h0000_0000}, '{32'h0, 1'b0, 1'b0}},
        '{1'b1, '{OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{32'h0, 1'b0, 1'b0}},
        // merge at an entry's end; the length wraps to zero
        '{1'b1, '{OP_RELEASE, 32'hFFFF_FFFE, 32'h0000_0001}, '{32'h0, 1'b0, 1'b0}},
        // size zero drops the zero-length entry now at the head
        '{1'b0, '{OP_ALLOC,   32'h0000_0000, 32'h0000_0000}, '{32'h0, 1'b0, 1'b0}},
        // table full and nothing to merge with: flagged
        '{1'b1, '{OP_RELEASE, 32'h2000_0000, 32'h0000_0008}, '{32'h0, 1'b0, 1'b1}},
        // table full but the release touches an entry: merges fine
        '{1'b0, '{OP_RELEASE, 32'h0000_00A0, 32'h0000_0010}, '{32'h0, 1'b0, 1'b0}},
        '{1'b0, '{OP_ALLOC,   32'h0000_0000, 32'hFFFF_FFFF}, '{32'h0, 1'b0, 1'b0}}
    };

    typedef struct {
        logic [31:0] base;
        logic [31:0] span;
    } held_extent_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_word  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_word;

    // predicted allocator state, mirrors the block after reset
    logic [31:0] ext_start [TABLE_DEPTH];
    logic [31:0] ext_len   [TABLE_DEPTH];
    int          ext_count  = 0;
    logic [31:0] append_ptr = 32'h0;

    out_word_t    pending_results [$];
    held_extent_t live_extents    [$];

    int   mismatches     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;

    free_extent_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Work out the result of one request against the predicted table and
    // update the table, pointer and count the way the block should.
    function automatic out_word_t place_extent(in_word_t w);
        out_word_t   r;
        logic        taken;
        logic        merged;
        logic [31:0] tail;
        logic [31:0] key_start;
        logic [31:0] key_len;
        int          j;
        r = '0;
        if (w.op == OP_ALLOC) begin
            taken = 1'b0;
            for (int i = 0; i < ext_count && !taken; i++) begin
                if (ext_len[i] >= w.extent_size) begin
                    r.placed_offset = ext_start[i];
                    ext_len[i]   = ext_len[i] - w.extent_size;
                    ext_start[i] = ext_start[i] + w.extent_size;
                    // drop a used-up extent and close the gap
                    if (ext_len[i] == 32'h0) begin
                        for (int k = i; k + 1 < ext_count; k++) begin
                            ext_start[k] = ext_start[k + 1];
                            ext_len[k]   = ext_len[k + 1];
                        end
                        ext_count--;
                    end
                    taken = 1'b1;
                end
            end
            if (!taken) begin
                r.placed_offset = append_ptr;
                r.placed_at_end = 1'b1;
                append_ptr      = append_ptr + w.extent_size;
            end
        end else if (w.extent_size != 32'h0) begin
            merged = 1'b0;
            // first entry touching either end wins; both ends may touch at once
            for (int i = 0; i < ext_count && !merged; i++) begin
                tail = ext_start[i] + ext_len[i];
                if (tail == w.extent_offset)
                    merged = 1'b1;
                tail = w.extent_offset + w.extent_size;
                if (tail == ext_start[i]) begin
                    ext_start[i] = w.extent_offset;
                    merged       = 1'b1;
                end
                if (merged)
                    ext_len[i] = ext_len[i] + w.extent_size;
            end
            if (!merged) begin
                if (ext_count < TABLE_DEPTH) begin
                    ext_start[ext_count] = w.extent_offset;
                    ext_len[ext_count]   = w.extent_size;
                    ext_count++;
                end else begin
                    r.table_full = 1'b1;
                end
            end
            // stable insertion sort by ascending length
            if (!r.table_full) begin
                for (int i = 1; i < ext_count; i++) begin
                    key_start = ext_start[i];
                    key_len   = ext_len[i];
                    j = i;
                    while (j > 0 && ext_len[j - 1] > key_len) begin
                        ext_start[j] = ext_start[j - 1];
                        ext_len[j]   = ext_len[j - 1];
                        j--;
                    end
                    ext_start[j] = key_start;
                    ext_len[j]   = key_len;
                end
            end
        end
        return r;
    endfunction

    // Build one random request. Most traffic is well formed: allocations of
    // sizes that fit the table, releases of earlier allocations, releases
    // that touch a free extent. The rest is noise with full-range fields.
    function automatic in_word_t next_request();
        in_word_t     w;
        held_extent_t h;
        int           pick;
        int           k;
        logic [31:0]  half;
        w.op            = OP_ALLOC;
        w.extent_offset = $urandom;
        w.extent_size   = $urandom_range(1, 64);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            case ($urandom_range(0, 9))
                0: w.extent_size = 32'h0;
                1: w.extent_size = $urandom;
                2: w.extent_size = 32'hFFFF_FFFF;
                3, 4: begin
                    if (ext_count > 0)
                        w.extent_size = ext_len[$urandom_range(0, ext_count - 1)];
                end
                default: ;
            endcase
        end else if (pick < 70 && live_extents.size() > 0) begin
            k = $urandom_range(0, live_extents.size() - 1);
            h = live_extents[k];
            w.op = OP_RELEASE;
            // now and then give back only the upper half and keep the rest
            if (h.span > 1 && $urandom_range(0, 3) == 0) begin
                half            = h.span >> 1;
                w.extent_offset = h.base + half;
                w.extent_size   = h.span - half;
                h.span          = half;
                live_extents[k] = h;
            end else begin
                w.extent_offset = h.base;
                w.extent_size   = h.span;
                live_extents.delete(k);
            end
        end else if (pick < 82 && ext_count > 0) begin
            k = $urandom_range(0, ext_count - 1);
            w.op = OP_RELEASE;
            if ($urandom_range(0, 1) == 0)
                w.extent_offset = ext_start[k] + ext_len[k];
            else
                w.extent_offset = ext_start[k] - w.extent_size;
        end else begin
            w.op = OP_RELEASE;
            case ($urandom_range(0, 7))
                0:       w.extent_size = 32'h0;
                1, 2:    w.extent_size = $urandom;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    // Offer one word, hold it until taken, then queue what it should return.
    task automatic send_request(input in_word_t w, input logic known, input out_word_t want);
        out_word_t    guess;
        held_extent_t held;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        guess = place_extent(w);
        pending_results.insert(pending_results.size(), known ? want : guess);
        // remember small allocations so later releases can give them back
        if (w.op == OP_ALLOC && w.extent_size != 32'h0 && w.extent_size <= LIVE_SIZE_MAX) begin
            held.base = guess.placed_offset;
            held.span = w.extent_size;
            live_extents.insert(live_extents.size(), held);
            if (live_extents.size() > LIVE_MAX)
                live_extents.delete(0);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Result side: random stalls per phase, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Check each result word against the oldest outstanding expectation.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected result word %h", m_word));
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_word.placed_offset !== want.placed_offset)
                    note_mismatch($sformatf("placed_offset %h, want %h",
                                            m_word.placed_offset, want.placed_offset));
                if (m_word.placed_at_end !== want.placed_at_end)
                    note_mismatch($sformatf("placed_at_end %b, want %b",
                                            m_word.placed_at_end, want.placed_at_end));
                if (m_word.table_full !== want.table_full)
                    note_mismatch($sformatf("table_full %b, want %b",
                                            m_word.table_full, want.table_full));
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        in_word_t fill_word;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; after the head rows leave one extent, fill the table
        // with spaced releases of falling length so every insert after the first reorders.
        for (int i = 0; i < PROBE_N; i++) begin
            send_request(PROBES[i].req, PROBES[i].known, PROBES[i].want);
            if (i == FILL_AFTER) begin
                for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
                    fill_word.op            = OP_RELEASE;
                    fill_word.extent_offset = 32'h1000_0000 + k * 32'h100;
                    fill_word.extent_size   = 32'h80 - k * 4;
                    send_request(fill_word, 1'b1, '0);
                end
            end
        end
        drain_results();

        // Random traffic, one idling pattern per phase; drain between phases.
        for (int ph = 0; ph < PHASE_N; ph++) begin
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // back up the result side while requests keep coming
                if (ph == 0 && n == 100)
                    hold_req = 1'b1;
                send_request(next_request(), 1'b0, '0);
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
sv/fea_pkg.sv
sv/fea_ram.sv
sv/fea_ctrl.sv
sv/fea_dpath.sv
sv/free_extent_allocator.sv
tb/tb_free_extent_allocator.sv
